/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel adjust block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define BCS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bcs: assertion failed");

// Clocked assertion that is also checked during reset.
`define BCS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bcs: assertion failed");

`endif

/* design/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg
// Types and constants shared by the brightness, contrast and saturation block.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int CFG_DATA_W = 15;

	// Rounding offset for a division by 255.
	localparam logic [7:0] BYTE_HALF = 8'd127;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_CONTRAST   = 2'd1,
		REG_SATURATION = 2'd2,
		REG_PREMULT    = 2'd3
	} reg_index_t;

	// Alpha sits in the lowest byte, as on the stream buses.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pix_t;

	// Settings as used by the datapath, already clamped to their ranges.
	typedef struct packed {
		logic signed [13:0] br;
		logic [14:0]        co;
		logic signed [13:0] sa;
		logic               pm;
		logic               ident;
	} cfg_t;

endpackage

/* design/bcs_div.sv */
// ----------------------------------------------------------------------------
// bcs_div
// Pipelined restoring divider, three lanes with a shared 8-bit divisor.
// One quotient bit is settled in each stage.
// ----------------------------------------------------------------------------
module bcs_div #(
	parameter int FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0][FRAC_BITS+7:0]     in_num,
	input  logic [7:0]                    in_den,
	input  bcs_pkg::pix_t                 in_pix,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0][FRAC_BITS+7:0]     out_quo,
	output bcs_pkg::pix_t                 out_pix
);

	localparam int NW = FRAC_BITS + 8;

	logic                vld_s [1:NW];
	logic [2:0][NW-1:0]  quo_s [1:NW];
	logic [2:0][7:0]     rem_s [1:NW];
	logic [7:0]          den_s [1:NW];
	bcs_pkg::pix_t       pix_s [1:NW];
	logic                stg_rdy [1:NW+1];

	assign stg_rdy[NW+1] = out_ready;
	assign in_ready      = stg_rdy[1];

	for (genvar st = 1; st <= NW; st++) begin : g_stage
		logic               prv_vld;
		logic [2:0][NW-1:0] prv_quo;
		logic [2:0][7:0]    prv_rem;
		logic [7:0]         prv_den;
		bcs_pkg::pix_t      prv_pix;
		logic [2:0][NW-1:0] quo_d;
		logic [2:0][7:0]    rem_d;

		if (st == 1) begin : g_first
			assign prv_vld = in_valid;
			assign prv_quo = in_num;
			assign prv_rem = '0;
			assign prv_den = in_den;
			assign prv_pix = in_pix;
		end else begin : g_next
			assign prv_vld = vld_s[st-1];
			assign prv_quo = quo_s[st-1];
			assign prv_rem = rem_s[st-1];
			assign prv_den = den_s[st-1];
			assign prv_pix = pix_s[st-1];
		end

		assign stg_rdy[st] = !vld_s[st] || stg_rdy[st+1];

		for (genvar ln = 0; ln < 3; ln++) begin : g_lane
			logic [8:0] part;
			logic [8:0] diff;
			logic       ge;

			assign part      = {prv_rem[ln], prv_quo[ln][NW-1]};
			assign ge        = part >= {1'b0, prv_den};
			assign diff      = part - {1'b0, prv_den};
			assign rem_d[ln] = ge ? diff[7:0] : part[7:0];
			assign quo_d[ln] = {prv_quo[ln][NW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st] <= 1'b0;
			end else if (stg_rdy[st]) begin
				vld_s[st] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[st] && prv_vld) begin
				quo_s[st] <= quo_d;
				rem_s[st] <= rem_d;
				den_s[st] <= prv_den;
				pix_s[st] <= prv_pix;
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_quo   = quo_s[NW];
	assign out_pix   = pix_s[NW];

endmodule

/* design/bcs_tone.sv */
// ----------------------------------------------------------------------------
// bcs_tone
// Brightness offset and contrast gain about one half, three stages.
// ----------------------------------------------------------------------------
module bcs_tone #(
	parameter int FRAC_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bcs_pkg::cfg_t                          cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0][FRAC_BITS+7:0]              in_x,
	input  bcs_pkg::pix_t                          in_pix,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [2:0][FRAC_BITS+27:0]             out_v,
	output bcs_pkg::pix_t                          out_pix
);

	localparam int F    = FRAC_BITS;
	localparam int NW   = F + 8;
	localparam int TW   = NW + 2;
	localparam int PW   = TW + 16;
	localparam int VW   = PW - F + 1;
	localparam int HALF = 2 ** (F - 1);

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 stg1_rdy, stg2_rdy, stg3_rdy;
	logic signed [TW-1:0] t_s1 [3];
	logic signed [PW-1:0] p_s2 [3];
	logic signed [VW-1:0] v_s3 [3];
	bcs_pkg::pix_t        pix_s1, pix_s2, pix_s3;
	logic signed [PW-1:0] p_rnd [3];

	assign stg3_rdy = !vld_s3 || out_ready;
	assign stg2_rdy = !vld_s2 || stg3_rdy;
	assign stg1_rdy = !vld_s1 || stg2_rdy;
	assign in_ready = stg1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (stg1_rdy) vld_s1 <= in_valid;
			if (stg2_rdy) vld_s2 <= vld_s1;
			if (stg3_rdy) vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int ln = 0; ln < 3; ln++) begin
			p_rnd[ln] = p_s2[ln] + PW'(HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (stg1_rdy && in_valid) begin
			for (int ln = 0; ln < 3; ln++) begin
				t_s1[ln] <= $signed({2'b00, in_x[ln]}) + TW'(cfg.br) - TW'(HALF);
			end
			pix_s1 <= in_pix;
		end
		if (stg2_rdy && vld_s1) begin
			for (int ln = 0; ln < 3; ln++) begin
				p_s2[ln] <= t_s1[ln] * $signed({1'b0, cfg.co});
			end
			pix_s2 <= pix_s1;
		end
		if (stg3_rdy && vld_s2) begin
			for (int ln = 0; ln < 3; ln++) begin
				v_s3[ln] <= VW'($signed(p_rnd[ln][PW-1:F])) + VW'(HALF);
			end
			pix_s3 <= pix_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_pix   = pix_s3;
	for (genvar ln = 0; ln < 3; ln++) begin : g_out
		assign out_v[ln] = (F + 28)'(v_s3[ln]);
	end

endmodule

/* design/bcs_sat.sv */
// ----------------------------------------------------------------------------
// bcs_sat
// Rec.709 luma and saturation mix, five stages.
// ----------------------------------------------------------------------------
module bcs_sat #(
	parameter int FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bcs_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0][FRAC_BITS+27:0]        in_v,
	input  bcs_pkg::pix_t                     in_pix,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0][FRAC_BITS+30:0]        out_v,
	output bcs_pkg::pix_t                     out_pix
);

	localparam int F    = FRAC_BITS;
	localparam int ONE  = 2 ** F;
	localparam int HALF = 2 ** (F - 1);
	localparam int VW   = F + 28;
	localparam int MW   = VW + 3;
	localparam int WW   = F + 2;
	localparam int PRW  = VW + WW;
	localparam int LSW  = PRW + 2;
	localparam int KW   = F + 3;
	localparam int DW   = VW + 1;
	localparam int DMW  = DW + KW;
	localparam int WR   = (2126 * ONE + 5000) / 10000;
	localparam int WB   = (722 * ONE + 5000) / 10000;
	localparam int WG   = ONE - WR - WB;
	localparam logic signed [WW-1:0] WR_Q = WW'(WR);
	localparam logic signed [WW-1:0] WG_Q = WW'(WG);
	localparam logic signed [WW-1:0] WB_Q = WW'(WB);

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                  stg1_rdy, stg2_rdy, stg3_rdy, stg4_rdy, stg5_rdy;
	logic signed [VW-1:0]  v_s1 [3];
	logic signed [VW-1:0]  v_s2 [3];
	logic signed [VW-1:0]  v_s3 [3];
	logic signed [VW-1:0]  v_s4 [3];
	logic signed [MW-1:0]  v_s5 [3];
	logic signed [PRW-1:0] wp_s1 [3];
	logic signed [KW-1:0]  k_s1, k_s2, k_s3;
	logic signed [VW-1:0]  luma_s2, luma_s3, luma_s4;
	logic signed [DW-1:0]  diff_s3 [3];
	logic signed [DMW-1:0] m_s4 [3];
	bcs_pkg::pix_t         pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic signed [LSW-1:0] luma_sum;
	logic signed [DMW-1:0] m_rnd [3];

	assign stg5_rdy = !vld_s5 || out_ready;
	assign stg4_rdy = !vld_s4 || stg5_rdy;
	assign stg3_rdy = !vld_s3 || stg4_rdy;
	assign stg2_rdy = !vld_s2 || stg3_rdy;
	assign stg1_rdy = !vld_s1 || stg2_rdy;
	assign in_ready = stg1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (stg1_rdy) vld_s1 <= in_valid;
			if (stg2_rdy) vld_s2 <= vld_s1;
			if (stg3_rdy) vld_s3 <= vld_s2;
			if (stg4_rdy) vld_s4 <= vld_s3;
			if (stg5_rdy) vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		luma_sum = LSW'(wp_s1[0]) + LSW'(wp_s1[1]) + LSW'(wp_s1[2]) + LSW'(HALF);
		for (int ln = 0; ln < 3; ln++) begin
			m_rnd[ln] = m_s4[ln] + DMW'(HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (stg1_rdy && in_valid) begin
			wp_s1[0] <= $signed(in_v[0]) * WR_Q;
			wp_s1[1] <= $signed(in_v[1]) * WG_Q;
			wp_s1[2] <= $signed(in_v[2]) * WB_Q;
			for (int ln = 0; ln < 3; ln++) begin
				v_s1[ln] <= $signed(in_v[ln]);
			end
			k_s1   <= KW'(ONE) + KW'(cfg.sa);
			pix_s1 <= in_pix;
		end
		if (stg2_rdy && vld_s1) begin
			luma_s2 <= $signed(luma_sum[F+VW-1:F]);
			v_s2    <= v_s1;
			k_s2    <= k_s1;
			pix_s2  <= pix_s1;
		end
		if (stg3_rdy && vld_s2) begin
			for (int ln = 0; ln < 3; ln++) begin
				diff_s3[ln] <= DW'(v_s2[ln]) - DW'(luma_s2);
			end
			luma_s3 <= luma_s2;
			v_s3    <= v_s2;
			k_s3    <= k_s2;
			pix_s3  <= pix_s2;
		end
		if (stg4_rdy && vld_s3) begin
			for (int ln = 0; ln < 3; ln++) begin
				m_s4[ln] <= diff_s3[ln] * k_s3;
			end
			luma_s4 <= luma_s3;
			v_s4    <= v_s3;
			pix_s4  <= pix_s3;
		end
		if (stg5_rdy && vld_s4) begin
			for (int ln = 0; ln < 3; ln++) begin
				if (cfg.sa == '0) begin
					v_s5[ln] <= MW'(v_s4[ln]);
				end else begin
					v_s5[ln] <= MW'(luma_s4) + MW'($signed(m_rnd[ln][DMW-1:F]));
				end
			end
			pix_s5 <= pix_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_pix   = pix_s5;
	for (genvar ln = 0; ln < 3; ln++) begin : g_out
		assign out_v[ln] = v_s5[ln];
	end

endmodule

/* design/bcs_out.sv */
// ----------------------------------------------------------------------------
// bcs_out
// Clamp to 0..1, round to 8 bits, premultiply again and select the
// pass-through pixel, three stages ending in the output register.
// ----------------------------------------------------------------------------
module bcs_out #(
	parameter int FRAC_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bcs_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0][FRAC_BITS+30:0]   in_v,
	input  bcs_pkg::pix_t                in_pix,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bcs_pkg::pix_t                out_pix
);

	localparam int F    = FRAC_BITS;
	localparam int ONE  = 2 ** F;
	localparam int HALF = 2 ** (F - 1);
	localparam int MW   = F + 31;
	localparam int BW   = F + 9;

	logic             vld_s1, vld_s2, vld_s3;
	logic             stg1_rdy, stg2_rdy, stg3_rdy;
	logic [7:0]       byte_s1 [3];
	logic [7:0]       byte_s2 [3];
	logic [15:0]      n_s2 [3];
	bcs_pkg::pix_t    pix_s1, pix_s2, pix_s3;
	logic [F:0]       clip [3];
	logic [BW-1:0]    scaled [3];
	logic [15:0]      n_bias [3];
	logic [15:0]      q_sum [3];
	logic [7:0]       chan [3];
	logic             bypass;

	assign stg3_rdy = !vld_s3 || out_ready;
	assign stg2_rdy = !vld_s2 || stg3_rdy;
	assign stg1_rdy = !vld_s1 || stg2_rdy;
	assign in_ready = stg1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (stg1_rdy) vld_s1 <= in_valid;
			if (stg2_rdy) vld_s2 <= vld_s1;
			if (stg3_rdy) vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int ln = 0; ln < 3; ln++) begin
			if ($signed(in_v[ln]) < 0) begin
				clip[ln] = '0;
			end else if ($signed(in_v[ln]) > MW'(ONE)) begin
				clip[ln] = (F+1)'(ONE);
			end else begin
				clip[ln] = in_v[ln][F:0];
			end
			scaled[ln] = {clip[ln], 8'h00} - BW'(clip[ln]) + BW'(HALF);
		end
	end

	// Division by 255 with half-up rounding, exact for the products of two bytes.
	always_comb begin
		bypass = cfg.ident || (pix_s2.alpha == 8'h00);
		for (int ln = 0; ln < 3; ln++) begin
			n_bias[ln] = n_s2[ln] + 16'(bcs_pkg::BYTE_HALF);
			q_sum[ln]  = n_bias[ln] + 16'd1 + {8'h00, n_bias[ln][15:8]};
			chan[ln]   = cfg.pm ? q_sum[ln][15:8] : byte_s2[ln];
		end
	end

	always_ff @(posedge clk) begin
		if (stg1_rdy && in_valid) begin
			for (int ln = 0; ln < 3; ln++) begin
				byte_s1[ln] <= scaled[ln][F+7:F];
			end
			pix_s1 <= in_pix;
		end
		if (stg2_rdy && vld_s1) begin
			for (int ln = 0; ln < 3; ln++) begin
				n_s2[ln] <= byte_s1[ln] * pix_s1.alpha;
			end
			byte_s2 <= byte_s1;
			pix_s2  <= pix_s1;
		end
		if (stg3_rdy && vld_s2) begin
			pix_s3.alpha <= pix_s2.alpha;
			pix_s3.red   <= bypass ? pix_s2.red   : chan[0];
			pix_s3.green <= bypass ? pix_s2.green : chan[1];
			pix_s3.blue  <= bypass ? pix_s2.blue  : chan[2];
		end
	end

	assign out_valid = vld_s3;
	assign out_pix   = pix_s3;

endmodule

/* design/pixel_brightness_contrast_saturation_core.sv */
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_saturation_core
// Brightness, contrast and saturation adjustment of 8-bit ARGB pixels.
//
// The core takes one pixel per clock while the output is not stalled and
// returns one adjusted pixel per pixel, in order. The depth is set by the
// divider that brings each channel to fixed point, which settles one
// quotient bit per stage; tone, saturation and output conversion add
// three, five and three stages. Valid bits travel with the data, and a
// stalled output holds the pipeline without losing pixels. Settings must
// be written through the register port only while no pixel is in flight;
// the core itself does not enforce this. Transparent pixels and identity
// settings pass unchanged.
// ----------------------------------------------------------------------------
module pixel_brightness_contrast_saturation_core #(
	parameter int FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// alpha_in [7:0], red_in [15:8], green_in [23:16], blue_in [31:24]
	input  logic [31:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// alpha_out [7:0], red_out [15:8], green_out [23:16], blue_out [31:24]
	output logic [31:0]                       m_axis_tdata
);

	localparam int F   = FRAC_BITS;
	localparam int ONE = 2 ** F;
	localparam int NW  = F + 8;
	localparam int VW  = F + 28;
	localparam int MW  = VW + 3;
	localparam logic [7:0] STRAIGHT_DEN = 8'd255;

	logic signed [13:0] brightness_q;
	logic [14:0]        contrast_q;
	logic signed [13:0] saturation_q;
	logic               premult_q;
	bcs_pkg::cfg_t      cfg;

	bcs_pkg::pix_t      in_pix;
	logic [2:0][NW-1:0] num;
	logic [7:0]         den;

	logic               div_valid, div_ready;
	logic [2:0][NW-1:0] div_quo;
	bcs_pkg::pix_t      div_pix;
	logic               tone_valid, tone_ready;
	logic [2:0][VW-1:0] tone_v;
	bcs_pkg::pix_t      tone_pix;
	logic               sat_valid, sat_ready;
	logic [2:0][MW-1:0] sat_v;
	bcs_pkg::pix_t      sat_pix;
	bcs_pkg::pix_t      out_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
			contrast_q   <= 15'(ONE);
			saturation_q <= '0;
			premult_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (bcs_pkg::reg_index_t'(cfg_index))
				bcs_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data[13:0];
				bcs_pkg::REG_CONTRAST:   contrast_q   <= cfg_data;
				bcs_pkg::REG_SATURATION: saturation_q <= cfg_data[13:0];
				bcs_pkg::REG_PREMULT:    premult_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.pm    = premult_q;
		cfg.ident = (brightness_q == '0) && (32'(contrast_q) == ONE)
			&& (saturation_q == '0);
		if (brightness_q > ONE) begin
			cfg.br = 14'(ONE);
		end else if (brightness_q < -ONE) begin
			cfg.br = 14'(-ONE);
		end else begin
			cfg.br = brightness_q;
		end
		if (32'(contrast_q) > 4 * ONE) begin
			cfg.co = 15'(4 * ONE);
		end else begin
			cfg.co = contrast_q;
		end
		if (saturation_q > ONE) begin
			cfg.sa = 14'(ONE);
		end else if (saturation_q < -ONE) begin
			cfg.sa = 14'(-ONE);
		end else begin
			cfg.sa = saturation_q;
		end
	end

	// Straight colour is divided by 255, premultiplied colour by alpha.
	always_comb begin
		in_pix = bcs_pkg::pix_t'(s_axis_tdata);
		den    = premult_q ? in_pix.alpha : STRAIGHT_DEN;
		num[0] = {in_pix.red,   F'(0)} + NW'(premult_q ? in_pix.alpha >> 1 : bcs_pkg::BYTE_HALF);
		num[1] = {in_pix.green, F'(0)} + NW'(premult_q ? in_pix.alpha >> 1 : bcs_pkg::BYTE_HALF);
		num[2] = {in_pix.blue,  F'(0)} + NW'(premult_q ? in_pix.alpha >> 1 : bcs_pkg::BYTE_HALF);
	end

	bcs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_num    (num),
		.in_den    (den),
		.in_pix    (in_pix),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_quo   (div_quo),
		.out_pix   (div_pix)
	);

	bcs_tone #(.FRAC_BITS(FRAC_BITS)) u_tone (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_x      (div_quo),
		.in_pix    (div_pix),
		.out_valid (tone_valid),
		.out_ready (tone_ready),
		.out_v     (tone_v),
		.out_pix   (tone_pix)
	);

	bcs_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (tone_valid),
		.in_ready  (tone_ready),
		.in_v      (tone_v),
		.in_pix    (tone_pix),
		.out_valid (sat_valid),
		.out_ready (sat_ready),
		.out_v     (sat_v),
		.out_pix   (sat_pix)
	);

	bcs_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sat_valid),
		.in_ready  (sat_ready),
		.in_v      (sat_v),
		.in_pix    (sat_pix),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix)
	);

	assign m_axis_tdata = out_pix;

endmodule

/* design/bcs_checker.sv */
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks of the pixel adjust core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcs_checker #(
	parameter int FRAC_BITS = 12
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	localparam int DEPTH = FRAC_BITS + 19;
	localparam int OCC_W = $clog2(DEPTH + 1) + 1;

	logic [OCC_W-1:0] occ_q;
	logic             in_take;
	logic             out_take;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_take = m_axis_tvalid && m_axis_tready;

	// Count of requests accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_take) - OCC_W'(out_take);
		end
	end

	`BCS_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	`BCS_ASSERT(a_ready_flow, clk, arst_n, m_axis_tready |-> s_axis_tready)
	`BCS_ASSERT(a_no_extra, clk, arst_n, m_axis_tvalid |-> occ_q != '0)
	`BCS_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OCC_W'(DEPTH))
	`BCS_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid)

endmodule

bind pixel_brightness_contrast_saturation_core bcs_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_bcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
